FILE: hw/rtl/hta_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hta_pkg
// Shared types and constants for the handle table allocator.
// ============================================================================
package hta_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int RESERVED_COUNT = 4;
    localparam int HANDLE_W       = 10;
    localparam int VALUE_W        = 64;
    localparam int ACTION_W       = 2;
    localparam int STATUS_W       = 2;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALSE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRUE  = 2'd2;

    // reserved handles, low two bits
    localparam logic [1:0] HND_ZERO  = 2'd0;
    localparam logic [1:0] HND_NONE  = 2'd1;
    localparam logic [1:0] HND_FALSE = 2'd2;
    localparam logic [1:0] HND_TRUE  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  obj_value;
    } hta_in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [VALUE_W-1:0]  out_value;
        logic [STATUS_W-1:0] status;
    } hta_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } hta_state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } hta_cmd_t;

endpackage

FILE: hw/rtl/hta_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// hta_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module hta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/hta_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// hta_ctrl
// Sequencer: accept, read table entry, execute and emit the result.
// ============================================================================
module hta_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output hta_pkg::hta_cmd_t cmd
);

    hta_pkg::hta_state_t state_reg;
    hta_pkg::hta_state_t state_next;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hta_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == hta_pkg::S_EXEC);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hta_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = hta_pkg::S_READ;
                end
            end
            hta_pkg::S_READ: state_next = hta_pkg::S_EXEC;
            hta_pkg::S_EXEC: state_next = hta_pkg::S_IDLE;
            default:         state_next = hta_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            hta_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            hta_pkg::S_READ: cmd.rd   = 1'b1;
            hta_pkg::S_EXEC: cmd.exec = 1'b1;
            default:         busy     = 1'b1;
        endcase
    end

    assign done = done_reg;

`ifndef ASSERT_OFF
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == hta_pkg::S_EXEC))
        else $error("done without an executed transaction");

    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == hta_pkg::S_READ) && busy)
        else $error("accepted transaction did not enter read");
`endif

endmodule

FILE: hw/rtl/hta_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// hta_datapath
// Item and config registers, free-list head, high-water mark, table RAMs.
// ============================================================================
module hta_datapath #(
    parameter int TABLE_SIZE = hta_pkg::TABLE_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hta_pkg::hta_cmd_t                   cmd,
    input  hta_pkg::hta_in_t                    item,
    input  logic                                cfg_we,
    input  logic [hta_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hta_pkg::VALUE_W-1:0]         cfg_data,
    output hta_pkg::hta_out_t                   result
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CW     = $clog2(TABLE_SIZE + 1);
    localparam int CMP_W  = (CW > hta_pkg::HANDLE_W) ? CW : hta_pkg::HANDLE_W;
    localparam int META_W = CW + 1;
    localparam logic [CW-1:0]    FULL_MARK = CW'(TABLE_SIZE);
    localparam logic [CW-1:0]    HW_RESET  = CW'(hta_pkg::RESERVED_COUNT);
    localparam logic [CMP_W-1:0] RSV_LIMIT = CMP_W'(hta_pkg::RESERVED_COUNT);

    hta_pkg::hta_in_t            item_reg;
    hta_pkg::hta_out_t           result_reg;
    hta_pkg::hta_out_t           result_next;
    logic [hta_pkg::VALUE_W-1:0] none_reg;
    logic [hta_pkg::VALUE_W-1:0] false_reg;
    logic [hta_pkg::VALUE_W-1:0] true_reg;
    logic [CW-1:0]               fh_reg;
    logic [CW-1:0]               fh_next;
    logic [CW-1:0]               hw_reg;
    logic [CW-1:0]               hw_next;

    logic [CMP_W-1:0]            h_ext;
    logic [IDX_W-1:0]            h_idx;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            slot;
    logic [CMP_W-1:0]            slot_ext;
    logic [IDX_W-1:0]            wr_addr;
    logic                        val_we;
    logic                        meta_we;
    logic [META_W-1:0]           meta_wdata;
    logic [META_W-1:0]           meta_rd;
    logic [hta_pkg::VALUE_W-1:0] value_rd;
    logic                        live;

    assign h_ext   = CMP_W'(item_reg.handle);
    assign h_idx   = h_ext[IDX_W-1:0];
    assign rd_addr = (item_reg.action == hta_pkg::ACT_ALLOC) ? fh_reg[IDX_W-1:0] : h_idx;
    assign live    = (h_ext >= RSV_LIMIT) && (h_ext < CMP_W'(hw_reg)) && meta_rd[CW];
    assign slot_ext = CMP_W'(slot);

    // meta entry: {in_use, free-list link}
    hta_ram #(.WIDTH(META_W), .DEPTH(TABLE_SIZE)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (wr_addr),
        .wdata (meta_wdata),
        .re    (cmd.rd),
        .raddr (rd_addr),
        .rdata (meta_rd)
    );

    hta_ram #(.WIDTH(hta_pkg::VALUE_W), .DEPTH(TABLE_SIZE)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (item_reg.obj_value),
        .re    (cmd.rd),
        .raddr (rd_addr),
        .rdata (value_rd)
    );

    always_comb
    begin
        fh_next                = fh_reg;
        hw_next                = hw_reg;
        slot                   = fh_reg[IDX_W-1:0];
        wr_addr                = h_idx;
        val_we                 = 1'b0;
        meta_we                = 1'b0;
        meta_wdata             = {1'b0, fh_reg};
        result_next.out_handle = item_reg.handle;
        result_next.out_value  = '0;
        result_next.status     = hta_pkg::ST_OK;
        case (item_reg.action)
            hta_pkg::ACT_ALLOC:
            begin
                if (fh_reg != FULL_MARK)
                begin
                    slot    = fh_reg[IDX_W-1:0];
                    fh_next = meta_rd[CW-1:0];
                end
                else if (hw_reg != FULL_MARK)
                begin
                    slot    = hw_reg[IDX_W-1:0];
                    hw_next = hw_reg + CW'(1);
                end
                else
                begin
                    slot               = '0;
                    result_next.status = hta_pkg::ST_FULL;
                end
                if (result_next.status == hta_pkg::ST_OK)
                begin
                    val_we     = cmd.exec;
                    meta_we    = cmd.exec;
                    wr_addr    = slot;
                    meta_wdata = {1'b1, fh_reg};
                end
                result_next.out_handle = slot_ext[hta_pkg::HANDLE_W-1:0];
            end
            hta_pkg::ACT_LOOKUP:
            begin
                if (h_ext < RSV_LIMIT)
                begin
                    case (item_reg.handle[1:0])
                        hta_pkg::HND_ZERO:  result_next.out_value = '0;
                        hta_pkg::HND_NONE:  result_next.out_value = none_reg;
                        hta_pkg::HND_FALSE: result_next.out_value = false_reg;
                        hta_pkg::HND_TRUE:  result_next.out_value = true_reg;
                        default:            result_next.out_value = '0;
                    endcase
                end
                else if (live)
                begin
                    result_next.out_value = value_rd;
                end
                else
                begin
                    result_next.status = hta_pkg::ST_BAD;
                end
            end
            hta_pkg::ACT_CLOSE:
            begin
                if (live)
                begin
                    meta_we    = cmd.exec;
                    meta_wdata = {1'b0, fh_reg};
                    fh_next    = h_ext[CW-1:0];
                end
                else
                begin
                    result_next.status = hta_pkg::ST_BAD;
                end
            end
            default: result_next.status = hta_pkg::ST_BAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg    <= FULL_MARK;
            hw_reg    <= HW_RESET;
            none_reg  <= '0;
            false_reg <= '0;
            true_reg  <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                fh_reg <= fh_next;
                hw_reg <= hw_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    hta_pkg::CFG_NONE:  none_reg  <= cfg_data;
                    hta_pkg::CFG_FALSE: false_reg <= cfg_data;
                    hta_pkg::CFG_TRUE:  true_reg  <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

`ifndef ASSERT_OFF
    a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg >= HW_RESET) && (hw_reg <= FULL_MARK))
        else $error("high-water mark out of range");

    a_fh_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fh_reg == FULL_MARK) || (fh_reg < hw_reg))
        else $error("free-list head points at a never-used slot");
`endif

endmodule

FILE: hw/rtl/handle_table_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// handle_table_allocator
// Fixed-size handle table with a LIFO free list (allocate, lookup, close).
// ============================================================================
// Usage:
//   Command channel: drive item and pulse start while busy is low; the
//   transaction is taken at that edge and busy rises the next cycle.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver takes it in that cycle and cannot stall it.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no transaction is in flight.
//   Order: done rises after the execute state and the result is taken at
//   the edge that ends done; busy drops together with the rise of done, so
//   the next transaction can be taken at that same edge, but none while one
//   is in flight. The fixed sequence is accept, registered RAM read of the
//   free-list head (allocate) or addressed slot, then execute and write back.
//   Reset: free list empty, high-water mark at 4, reserved values cleared.
//   No clearing pass; the table is usable right after reset.
// ============================================================================
module handle_table_allocator #(
    parameter int TABLE_SIZE = hta_pkg::TABLE_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  hta_pkg::hta_in_t                item,
    output logic                            done,
    output hta_pkg::hta_out_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hta_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hta_pkg::VALUE_W-1:0]     cfg_data
);

    hta_pkg::hta_cmd_t cmd;

    assign cfg_ready = 1'b1;

    hta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    hta_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

FILE: test/handle_table_allocator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// handle_table_allocator_tb
// Self-checking bench for the handle table allocator. A scoreboard class
// keeps its own copy of the table, the free list and the reserved values,
// predicts every result at the accepting edge, and checks results in order.
// The stimulus starts with directed cases, then runs random phases, a fill
// to table full, and reserved-value register changes between phases.
// ============================================================================
module handle_table_allocator_tb;
    import hta_pkg::*;

    localparam int TBL          = TABLE_SIZE_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 350;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    class handle_scoreboard;
        logic [VALUE_W-1:0] fixed_value[RESERVED_COUNT];
        logic [VALUE_W-1:0] slot_value[TBL];
        int unsigned        free_link[TBL];
        bit                 slot_live[TBL];
        int unsigned        free_top;
        int unsigned        fresh_slot;
        int unsigned        live_count;
        hta_out_t           pending_q[$];
        int                 errors;
        int                 n_items;
        int                 n_checked;
        int                 n_full;
        int                 n_bad;

        function new();
            foreach (fixed_value[i])
                fixed_value[i] = '0;
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            free_top   = TBL;
            fresh_slot = RESERVED_COUNT;
            live_count = 0;
            errors     = 0;
            n_items    = 0;
            n_checked  = 0;
            n_full     = 0;
            n_bad      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
            case (idx)
                CFG_NONE:  fixed_value[HND_NONE]  = val;
                CFG_FALSE: fixed_value[HND_FALSE] = val;
                CFG_TRUE:  fixed_value[HND_TRUE]  = val;
                default: ;
            endcase
        endfunction

        function bit is_live(int unsigned h);
            return h >= RESERVED_COUNT && h < fresh_slot && slot_live[h];
        endfunction

        function bit table_full();
            return free_top >= TBL && fresh_slot >= TBL;
        endfunction

        function int unsigned pick_live();
            int unsigned h;
            if (live_count != 0)
            begin
                repeat (32)
                begin
                    h = $urandom_range(fresh_slot - 1, RESERVED_COUNT);
                    if (slot_live[h])
                        return h;
                end
            end
            return $urandom_range(TBL - 1, 0);
        endfunction

        // update the table for one accepted transaction, queue its result
        function void note_input(hta_in_t it);
            hta_out_t    exp_r;
            int unsigned h;
            int unsigned slot;
            h                = it.handle;
            slot             = 0;
            exp_r.out_handle = it.handle;
            exp_r.out_value  = '0;
            exp_r.status     = ST_OK;
            case (it.action)
                ACT_ALLOC:
                begin
                    if (free_top < TBL)
                    begin
                        slot     = free_top;
                        free_top = free_link[slot];
                    end
                    else if (fresh_slot < TBL)
                    begin
                        slot       = fresh_slot;
                        fresh_slot = fresh_slot + 1;
                    end
                    else
                        exp_r.status = ST_FULL;
                    if (exp_r.status == ST_OK)
                    begin
                        slot_value[slot] = it.obj_value;
                        slot_live[slot]  = 1'b1;
                        live_count       = live_count + 1;
                    end
                    exp_r.out_handle = HANDLE_W'(slot);
                end
                ACT_LOOKUP:
                begin
                    if (h < RESERVED_COUNT)
                        exp_r.out_value = fixed_value[h];
                    else if (is_live(h))
                        exp_r.out_value = slot_value[h];
                    else
                        exp_r.status = ST_BAD;
                end
                ACT_CLOSE:
                begin
                    if (is_live(h))
                    begin
                        slot_live[h] = 1'b0;
                        free_link[h] = free_top;
                        free_top     = h;
                        live_count   = live_count - 1;
                    end
                    else
                        exp_r.status = ST_BAD;
                end
                default:
                    exp_r.status = ST_BAD;
            endcase
            if (exp_r.status == ST_FULL)
                n_full++;
            if (exp_r.status == ST_BAD)
                n_bad++;
            n_items++;
            pending_q.push_back(exp_r);
        endfunction

        function void check_result(hta_out_t got);
            hta_out_t exp_r;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: out_handle %0d out_value %h status %0d",
                       got.out_handle, got.out_value, got.status);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            n_checked++;
            if (got.out_handle !== exp_r.out_handle)
            begin
                $error("out_handle: expected %0d, got %0d", exp_r.out_handle, got.out_handle);
                errors++;
            end
            if (got.out_value !== exp_r.out_value)
            begin
                $error("out_value: expected %h, got %h", exp_r.out_value, got.out_value);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    hta_in_t                item      = '0;
    logic                   done;
    hta_out_t               result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]     cfg_data  = '0;

    handle_scoreboard sb;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    int               n_cfg       = 0;

    handle_table_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** handle_table_allocator: FAILED **");
            $finish;
        end
    end

    function logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // bursts of back-to-back commands separated by random gaps
    task automatic send(hta_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            burst_left = $urandom_range(30, 1);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_input(it);
    endtask

    task automatic send_op(logic [ACTION_W-1:0] act, int unsigned h, logic [VALUE_W-1:0] v);
        hta_in_t it;
        it.action    = act;
        it.handle    = HANDLE_W'(h);
        it.obj_value = v;
        send(it);
    endtask

    task automatic drain();
        start      <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
        n_cfg++;
    endtask

    task automatic write_regs(logic [VALUE_W-1:0] none_v, logic [VALUE_W-1:0] false_v,
                              logic [VALUE_W-1:0] true_v);
        drain();
        write_one(CFG_NONE, none_v);
        write_one(CFG_FALSE, false_v);
        write_one(CFG_TRUE, true_v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed traffic on live handles, some noise
    task automatic random_item();
        int unsigned pick;
        int unsigned roll;
        int unsigned sel;
        roll = $urandom_range(99, 0);
        pick = $urandom_range(TBL - 1, 0);
        sel  = $urandom_range(9, 0);
        if (roll < 38)
            send_op(ACT_ALLOC, pick, rand_value());
        else if (roll < 70)
        begin
            if (sel < 8)
                pick = sb.pick_live();
            else if (sel == 8)
                pick = $urandom_range(RESERVED_COUNT - 1, 0);
            send_op(ACT_LOOKUP, pick, rand_value());
        end
        else if (roll < 93)
        begin
            if (sel < 8)
                pick = sb.pick_live();
            send_op(ACT_CLOSE, pick, rand_value());
        end
        else
            send_op(ACT_UNUSED, pick, rand_value());
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs('1, '0, 64'hA5A5_5A5A_F00D_0001);

        for (int i = 0; i < RESERVED_COUNT; i++)
            send_op(ACT_LOOKUP, i, rand_value());
        send_op(ACT_LOOKUP, RESERVED_COUNT, '1);
        send_op(ACT_CLOSE, HND_FALSE, '0);
        send_op(ACT_CLOSE, TBL - 1, '1);
        send_op(ACT_UNUSED, TBL - 1, '1);
        send_op(ACT_ALLOC, 0, '0);
        send_op(ACT_ALLOC, TBL - 1, '1);
        send_op(ACT_ALLOC, 0, 64'h0123_4567_89AB_CDEF);
        for (int i = RESERVED_COUNT; i < RESERVED_COUNT + 3; i++)
            send_op(ACT_LOOKUP, i, '0);
        // double close, lookup of a freed slot, then LIFO reuse
        send_op(ACT_CLOSE, RESERVED_COUNT + 1, '0);
        send_op(ACT_CLOSE, RESERVED_COUNT + 1, '0);
        send_op(ACT_LOOKUP, RESERVED_COUNT + 1, '0);
        send_op(ACT_CLOSE, RESERVED_COUNT, '0);
        repeat (3) send_op(ACT_ALLOC, 0, rand_value());
        send_op(ACT_LOOKUP, RESERVED_COUNT + 3, '0);
        send_op(ACT_LOOKUP, RESERVED_COUNT + 4, '0);

        write_regs(rand_value(), rand_value(), rand_value());
        repeat (RANDOM_ITEMS) random_item();

        // fill the table, then exercise table full and the top handle
        write_regs('0, '1, '1);
        while (!sb.table_full())
            send_op(ACT_ALLOC, $urandom_range(TBL - 1, 0), rand_value());
        repeat (3) send_op(ACT_ALLOC, $urandom_range(TBL - 1, 0), rand_value());
        send_op(ACT_LOOKUP, TBL - 1, '0);
        send_op(ACT_CLOSE, TBL - 1, '0);
        send_op(ACT_ALLOC, 0, '1);
        send_op(ACT_LOOKUP, TBL - 1, '0);
        send_op(ACT_ALLOC, 0, '1);
        repeat (40) send_op(ACT_CLOSE, sb.pick_live(), rand_value());

        write_regs(rand_value(), rand_value(), rand_value());
        repeat (RANDOM_ITEMS) random_item();

        drain();
        $display("run covered %0d transactions (%0d checked): %0d table-full, %0d bad-handle",
                 sb.n_items, sb.n_checked, sb.n_full, sb.n_bad);
        $display("reserved-value registers written %0d times", n_cfg);
        if (sb.errors == 0)
            $display("** handle_table_allocator: PASSED **");
        else
            $display("** handle_table_allocator: FAILED **");
        $finish;
    end

endmodule
